/* src/mtf_pkg.sv */
package mtf_pkg;

  localparam int SYM_W    = 8;
  localparam int LIST_LEN = 1 << SYM_W;

  typedef logic [SYM_W-1:0] sym_t;

  typedef struct packed {
    logic valid;
    logic sob;
    logic found;
    sym_t sym;
    sym_t carry;
    sym_t rank;
  } tok_t;

  function automatic sym_t init_value(input sym_t pos);
    sym_t v;
    v = pos;
    if (!pos[SYM_W-1]) begin
      v[SYM_W-2 -: 2] = ~pos[SYM_W-2 -: 2];
    end
    return v;
  endfunction

endpackage

/* src/mtf_cell.sv */
module mtf_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  mtf_pkg::tok_t tok_i,
  output mtf_pkg::tok_t tok_o
);
  import mtf_pkg::*;

  localparam sym_t POS = SYM_W'(IDX);

  sym_t val_r;
  sym_t val_nxt;
  sym_t cur;
  tok_t tok_r;
  tok_t tok_nxt;

  always_comb begin
    cur     = tok_i.sob ? init_value(POS) : val_r;
    val_nxt = val_r;
    tok_nxt = tok_i;
    if (tok_i.valid) begin
      val_nxt = cur;
      if (!tok_i.found) begin
        val_nxt       = tok_i.carry;
        tok_nxt.carry = cur;
        if (cur == tok_i.sym) begin
          tok_nxt.found = 1'b1;
          tok_nxt.rank  = POS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= init_value(POS);
      tok_r <= '0;
    end else if (en) begin
      val_r <= val_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

  a_take_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (en && tok_i.valid && !tok_i.found) |=> (val_r == $past(tok_i.carry)))
    else $error("cell did not take the carried word");

  a_hit_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (en && tok_i.valid && !tok_i.found && cur == tok_i.sym)
      |=> (tok_r.found && tok_r.rank == POS))
    else $error("hit not marked with this position");

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_r.valid && tok_r.found) |-> (tok_r.rank <= POS))
    else $error("rank beyond this cell");

endmodule

/* src/move_to_front_encoder_top.sv */
// Move-to-front encoder over a 256-entry byte list kept in a row of 256
// cells, one entry per cell. Each accepted word walks down the row one
// cell per clock when not stalled, swapping entries until it meets its
// own byte, so words enter back to back at one per cycle and each rank
// leaves the register of the last cell. The whole row stalls while the
// output word waits. A word with in_tuser set reloads the initial order
// (positions 0-31 hold 96-127, 32-63 hold 64-95, 64-95 hold 32-63, 96-127
// hold 0-31, the rest hold themselves) ahead of its own lookup; reset
// loads the same order.
module move_to_front_encoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  input  logic       in_tuser,   // [0] start_of_block
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [7:0] rank
);
  import mtf_pkg::*;

  tok_t tok [0:LIST_LEN];
  logic en;

  assign en = !tok[LIST_LEN].valid || out_tready;

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = in_tvalid;
    tok[0].sob   = in_tuser;
    tok[0].sym   = in_tdata;
    tok[0].carry = in_tdata;
  end

  for (genvar i = 0; i < LIST_LEN; i++) begin : g_cell
    mtf_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tok_i (tok[i]),
      .tok_o (tok[i+1])
    );
  end

  assign in_tready  = en;
  assign out_tvalid = tok[LIST_LEN].valid;
  assign out_tdata  = tok[LIST_LEN].rank;

  a_found_at_exit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> tok[LIST_LEN].found)
    else $error("word left the row without a hit");

  a_front_is_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    (tok[1].valid && tok[1].found) |-> (tok[1].rank == '0))
    else $error("front cell result inconsistent");

  a_no_sob_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (tok[1].valid && tok[1].sob == $past(in_tuser)))
    else $error("accepted word lost at the front cell");

endmodule
